FILE: rtl/ssea_pkg.sv
// ----------------------------------------------------------------------------
// Sorted sparse entry accumulator package
// Sizes, entry layout, operation and status codes, register indexes.
// ----------------------------------------------------------------------------
package ssea_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;

  typedef struct packed {
    logic [15:0]        row;
    logic [15:0]        col;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

  typedef enum logic [1:0] {
    FN_ADD    = 2'd0,
    FN_LOOKUP = 2'd1,
    FN_READ   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_ACCUMULATED = 3'd1,
    ST_REMOVED     = 3'd2,
    ST_ZERO        = 3'd3,
    ST_RANGE       = 3'd4,
    ST_FULL        = 3'd5,
    ST_FOUND       = 3'd6,
    ST_MISSING     = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    CFG_ROW_LIMIT = 2'd0,
    CFG_COL_LIMIT = 2'd1,
    CFG_ZERO_THR  = 2'd2
  } cfg_index_t;

endpackage

FILE: rtl/ssea_store.sv
// ----------------------------------------------------------------------------
// Entry store
// Single-port-write, single-port-read table of sorted entries, registered read.
// ----------------------------------------------------------------------------
module ssea_store
  import ssea_pkg::*;
(
  input  logic              clk,
  input  mem_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/sorted_sparse_entry_accumulator.sv
// ----------------------------------------------------------------------------
// Sorted sparse entry accumulator
// Holds up to CAPACITY sparse matrix entries sorted by row then column, with
// accumulate, cancel-and-remove, ordered insert, lookup and positional read.
//
//   Channel  Signals                              Direction
//   input    s_tvalid s_tready s_tdata s_tuser    in
//   result   m_tvalid m_tready m_tdata m_tuser    out
//   config   cfg_valid cfg_ready cfg_index cfg_data  in
//
// One item at a time; s_tready is high only between items.
// Add and lookup scan the stored entries one at a time, with a read state and a
// compare state per entry visited; an insert or a removal then moves each later
// entry with a read state and a write state, through the single read and write
// port of the entry store.
// Reset empties the table at once; no clearing pass is needed.
// A finished result waits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module sorted_sparse_entry_accumulator
  import ssea_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,    // row_index[15:0], col_index[31:16], add_value[63:32],
                                  // position[71:64]
  input  logic [1:0]  s_tuser,    // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,    // out_value[31:0], out_row[47:32], out_col[63:48],
                                  // entry_total[72:64], zero[79:73]
  output logic [2:0]  m_tuser,    // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CMP, S_DECIDE, S_ACC, S_RDPOS,
    S_DOWN_RD, S_DOWN_WR, S_UP_RD, S_UP_WR, S_FINISH
  } state_t;

  state_t state;

  logic [15:0] row_limit;
  logic [15:0] col_limit;
  logic [30:0] zero_thr;
  logic [CNT_W-1:0] count;

  // Latched item.
  logic [1:0]         func;
  logic [15:0]        row;
  logic [15:0]        col;
  logic signed [31:0] val;
  logic [7:0]         pos;

  logic [CNT_W-1:0]   idx;  // lower bound position
  logic [CNT_W-1:0]   mov;  // position being moved
  logic               hit;
  logic signed [31:0] cur_val;
  logic signed [32:0] sum;

  logic [2:0]         res_status;
  logic signed [31:0] res_value;
  logic [15:0]        res_row;
  logic [15:0]        res_col;

  mem_wr_t           wr;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;

  ssea_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  logic [31:0]        val_mag;
  logic               val_zero;
  logic               out_of_range;
  logic [31:0]        rd_key;
  logic [31:0]        key;
  logic [32:0]        sum_mag;
  logic               cancel;
  logic signed [31:0] sum_sat;
  logic [CNT_W-1:0]   mov_up;
  logic [CNT_W-1:0]   mov_dn;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign val_mag      = val[31] ? 32'(-val) : 32'(val);
  assign val_zero     = val_mag < {1'b0, zero_thr};
  assign out_of_range = (row >= row_limit) || (col >= col_limit);
  assign key          = {row, col};
  assign rd_key       = {rd_data.row, rd_data.col};
  assign sum_mag      = sum[32] ? 33'(-sum) : 33'(sum);
  assign cancel       = sum_mag < {2'b00, zero_thr};
  assign mov_up       = mov + 1'b1;
  assign mov_dn       = mov - 1'b1;

  // Saturate the 33-bit sum to the stored 32-bit range.
  always_comb begin
    if (sum[32] != sum[31]) begin
      sum_sat = sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum[31:0];
    end
  end

  // Entry store addressing.
  always_comb begin
    rd_addr = '0;
    wr      = '0;
    case (state)
      S_CHECK:   rd_addr = pos[ADDR_W-1:0];
      S_SCAN_RD: rd_addr = idx[ADDR_W-1:0];
      S_ACC: begin
        if (!cancel) begin
          wr.en   = 1'b1;
          wr.addr = idx[ADDR_W-1:0];
          wr.data = '{row: row, col: col, value: sum_sat};
        end
      end
      S_DOWN_RD: rd_addr = mov_up[ADDR_W-1:0];
      S_DOWN_WR: begin
        wr.en   = 1'b1;
        wr.addr = mov[ADDR_W-1:0];
        wr.data = rd_data;
      end
      S_UP_RD: begin
        if (mov == idx) begin
          wr.en   = 1'b1;
          wr.addr = idx[ADDR_W-1:0];
          wr.data = '{row: row, col: col, value: val};
        end else begin
          rd_addr = mov_dn[ADDR_W-1:0];
        end
      end
      S_UP_WR: begin
        wr.en   = 1'b1;
        wr.addr = mov[ADDR_W-1:0];
        wr.data = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      count     <= '0;
      row_limit <= 16'hFFFF;
      col_limit <= 16'hFFFF;
      zero_thr  <= 31'd1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW_LIMIT: row_limit <= cfg_data[15:0];
          CFG_COL_LIMIT: col_limit <= cfg_data[15:0];
          CFG_ZERO_THR:  zero_thr  <= cfg_data[30:0];
          default: ;
        endcase
      end

      // The finishing step reloads the output register on its own.
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func  <= s_tuser;
            row   <= s_tdata[15:0];
            col   <= s_tdata[31:16];
            val   <= s_tdata[63:32];
            pos   <= s_tdata[71:64];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_value <= '0;
          res_row   <= '0;
          res_col   <= '0;
          idx       <= '0;
          case (func)
            FN_ADD: begin
              if (val_zero) begin
                res_status <= ST_ZERO;
                state      <= S_FINISH;
              end else if (out_of_range) begin
                res_status <= ST_RANGE;
                state      <= S_FINISH;
              end else begin
                res_status <= ST_MISSING;
                state      <= S_SCAN_RD;
              end
            end
            FN_LOOKUP: begin
              if (out_of_range) begin
                res_status <= ST_RANGE;
                state      <= S_FINISH;
              end else begin
                res_status <= ST_MISSING;
                state      <= S_SCAN_RD;
              end
            end
            FN_READ: begin
              res_status <= ST_MISSING;
              if ({1'b0, pos} < count) begin
                state <= S_RDPOS;
              end else begin
                state <= S_FINISH;
              end
            end
            default: begin
              res_status <= ST_MISSING;
              state      <= S_FINISH;
            end
          endcase
        end
        S_RDPOS: begin
          res_status <= ST_FOUND;
          res_value  <= rd_data.value;
          res_row    <= rd_data.row;
          res_col    <= rd_data.col;
          state      <= S_FINISH;
        end
        S_SCAN_RD: begin
          if (idx == count) begin
            hit   <= 1'b0;
            state <= S_DECIDE;
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (rd_key < key) begin
            idx   <= idx + 1'b1;
            state <= S_SCAN_RD;
          end else begin
            hit     <= (rd_key == key);
            cur_val <= rd_data.value;
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (func == FN_LOOKUP) begin
            if (hit) begin
              res_status <= ST_FOUND;
              res_value  <= cur_val;
            end
            state <= S_FINISH;
          end else if (hit) begin
            sum   <= 33'(cur_val) + 33'(val);
            state <= S_ACC;
          end else if (count == CNT_W'(CAPACITY)) begin
            res_status <= ST_FULL;
            state      <= S_FINISH;
          end else begin
            mov   <= count;
            state <= S_UP_RD;
          end
        end
        S_ACC: begin
          if (cancel) begin
            mov   <= idx;
            state <= S_DOWN_RD;
          end else begin
            res_status <= ST_ACCUMULATED;
            res_value  <= sum_sat;
            state      <= S_FINISH;
          end
        end
        S_DOWN_RD: begin
          if (mov_up == count) begin
            count      <= count - 1'b1;
            res_status <= ST_REMOVED;
            state      <= S_FINISH;
          end else begin
            state <= S_DOWN_WR;
          end
        end
        S_DOWN_WR: begin
          mov   <= mov_up;
          state <= S_DOWN_RD;
        end
        S_UP_RD: begin
          if (mov == idx) begin
            count      <= count + 1'b1;
            res_status <= ST_INSERTED;
            res_value  <= val;
            state      <= S_FINISH;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          mov   <= mov_dn;
          state <= S_UP_RD;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {7'd0, count, res_col, res_row, res_value};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Writes stay within the occupied region plus the slot being inserted.
  a_write_addr: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> ({1'b0, wr.addr} <= count))
    else $error("store write beyond occupied entries");

  // The count moves by at most one per item.
  a_count_step: assert property (@(posedge clk) disable iff (rst || $past(rst))
    (count != $past(count)) |->
      ((count == $past(count) + 1'b1) || (count + 1'b1 == $past(count))))
    else $error("entry count jumped");

  // A new result only appears out of the finishing step.
  a_result_src: assert property (@(posedge clk) disable iff (rst || $past(rst))
    $rose(m_tvalid) |-> $past(state == S_FINISH))
    else $error("result raised outside finishing step");

  // An accepted item moves the sequencer from idle into the check step.
  a_idle_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_CHECK))
    else $error("accepted item did not start processing");

endmodule
